/* src/lkc_pkg.sv */
// shared types and constants for the keyed lru cache
// word layouts, command codes and sequencer states; no dependencies
package lkc_pkg;

	localparam int KEY_BITS        = 32;
	localparam int DATA_BITS       = 64;
	localparam int ERR_BITS        = 4;
	localparam int CAP_BITS        = 5;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef enum logic {
		CMD_GET   = 1'b0,
		CMD_PROBE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] fill_data;
		logic [ERR_BITS-1:0]  fill_error;
	} in_t;

	typedef struct packed {
		logic                 hit;
		logic [DATA_BITS-1:0] data_out;
		logic [ERR_BITS-1:0]  error_code;
		logic                 evicted;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RANK,
		ST_FIN
	} state_t;

endpackage

/* src/lru_keyed_cache.sv */
// sequence: a word is accepted in idle; a get then runs a scan pass over all entries, a
// decision state, a rank pass and a final state that loads the output register; a probe
// skips the rank pass
// a new word is accepted only in idle, after the previous one has loaded the output
// register, so words do not overlap on the memory ports; a stalled output holds the final state
// reset: no valid entries, count zero, capacity 16, output empty; memories need no clearing
module lru_keyed_cache #(
	parameter int MAX_ENTRIES = lkc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lkc_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lkc_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [lkc_pkg::CAP_BITS-1:0]  cfg_wdata
);
	import lkc_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int NW = IW + 1;
	localparam int CW = (NW > CAP_BITS) ? NW : CAP_BITS;
	localparam int PW = ERR_BITS + DATA_BITS;

	state_t state_q, state_d;

	in_t                  req_q;
	logic [CAP_BITS-1:0]  cap_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [NW-1:0]        count_q;
	logic [NW-1:0]        rd_idx_q;
	logic                 step_s1;
	logic [IW-1:0]        idx_s1;
	logic [IW-1:0]        slot_q;
	logic [NW-1:0]        old_q;
	logic                 hit_q, evict_q;
	logic                 out_valid_q;
	out_t                 out_q;

	logic                 accept, issue, load_out, sweep;
	logic [KEY_BITS-1:0]  key_rd;
	logic [IW-1:0]        rank_rd;
	logic [PW-1:0]        pay_rd;
	logic                 scan_hit, scan_free;
	logic [IW-1:0]        hit_slot, hit_rank, free_slot, lru_slot, lru_rank;
	logic [CW-1:0]        cap_w, cap_eff, cnt_w;
	logic                 use_free, miss_fill;
	logic [IW-1:0]        slot_d;
	logic [NW-1:0]        old_d;
	logic                 rank_we;
	logic [IW-1:0]        rank_wdata;
	logic [ERR_BITS-1:0]  pay_err;
	logic [DATA_BITS-1:0] pay_data;
	out_t                 result;

	assign accept = in_valid && in_ready;
	assign issue  = (rd_idx_q != NW'(MAX_ENTRIES));
	assign sweep  = (state_q == ST_SCAN) || (state_q == ST_RANK);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue && !step_s1) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (req_q.cmd == CMD_PROBE) ? ST_FIN : ST_RANK;
			end
			ST_RANK: begin
				if (!issue && !step_s1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// effective capacity, clamped to 1..MAX_ENTRIES
	always_comb begin
		cap_w = CW'(cap_q);
		cnt_w = CW'(count_q);
		if (cap_w == '0) begin
			cap_eff = CW'(1);
		end else if (cap_w > CW'(MAX_ENTRIES)) begin
			cap_eff = CW'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_w;
		end
	end

	assign use_free  = !scan_hit && (cnt_w < cap_eff);
	assign miss_fill = (state_q == ST_DECIDE) && (req_q.cmd == CMD_GET) && !scan_hit;

	always_comb begin
		if (scan_hit) begin
			slot_d = hit_slot;
			old_d  = NW'(hit_rank);
		end else if (use_free) begin
			slot_d = free_slot;
			old_d  = count_q;
		end else begin
			slot_d = lru_slot;
			old_d  = NW'(lru_rank);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			valid_q     <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			step_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE || state_q == ST_DECIDE) begin
				rd_idx_q <= '0;
			end else if (sweep && issue) begin
				rd_idx_q <= NW'(rd_idx_q + 1'b1);
			end
			step_s1 <= sweep && issue;
			if (miss_fill) begin
				valid_q[slot_d] <= 1'b1;
				if (use_free) begin
					count_q <= NW'(count_q + 1'b1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		idx_s1 <= rd_idx_q[IW-1:0];
		if (state_q == ST_DECIDE) begin
			slot_q  <= slot_d;
			old_q   <= old_d;
			hit_q   <= scan_hit;
			evict_q <= (req_q.cmd == CMD_GET) && !scan_hit && !use_free;
		end
		if (load_out) begin
			out_q <= result;
		end
	end

	lkc_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (MAX_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (miss_fill),
		.waddr (slot_d),
		.wdata (req_q.key),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (key_rd)
	);

	lkc_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_ENTRIES)
	) u_pay_ram (
		.clk   (clk),
		.we    (miss_fill),
		.waddr (slot_d),
		.wdata ({req_q.fill_error, req_q.fill_data}),
		.raddr (slot_q),
		.rdata (pay_rd)
	);

	// rank pass: the chosen slot takes rank 0, more recent valid entries move down one
	assign rank_we = (state_q == ST_RANK) && step_s1 &&
		((idx_s1 == slot_q) || (valid_q[idx_s1] && (NW'(rank_rd) < old_q)));
	assign rank_wdata = (idx_s1 == slot_q) ? '0 : IW'(rank_rd + 1'b1);

	lkc_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_ENTRIES)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rank_rd)
	);

	lkc_scan #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (accept),
		.step       (step_s1 && (state_q == ST_SCAN)),
		.idx        (idx_s1),
		.ent_valid  (valid_q[idx_s1]),
		.ent_key    (key_rd),
		.ent_rank   (rank_rd),
		.req_key    (req_q.key),
		.hit        (scan_hit),
		.hit_slot   (hit_slot),
		.hit_rank   (hit_rank),
		.free_found (scan_free),
		.free_slot  (free_slot),
		.lru_slot   (lru_slot),
		.lru_rank   (lru_rank)
	);

	assign pay_err  = pay_rd[PW-1:DATA_BITS];
	assign pay_data = pay_rd[DATA_BITS-1:0];

	always_comb begin
		result         = '0;
		result.hit     = hit_q;
		if (req_q.cmd == CMD_GET) begin
			result.error_code = pay_err;
			result.data_out   = (pay_err != '0) ? '0 : pay_data;
			result.evicted    = evict_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// entry count tracks the valid bits between words
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(valid_q) == int'(count_q)))
		else $error("entry count differs from number of valid entries");

	// below capacity a miss must have found a free slot
	a_free_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(miss_fill && use_free) |-> scan_free)
		else $error("fill below capacity without a free slot");

	// replacement needs at least one valid entry to pick from
	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(miss_fill && !use_free) |-> (count_q != '0))
		else $error("replacement with no valid entry");

endmodule

/* src/lkc_ram.sv */
// one write port, one read port ram with registered read data
// used for keys, payloads and recency ranks; no dependencies
module lkc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* src/lkc_scan.sv */
// shared compare unit: looks at one entry per step and keeps the key match,
// the first free slot and the least recent valid entry; uses lkc_pkg
module lkc_scan #(
	parameter int MAX_ENTRIES = lkc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            step,
	input  logic [$clog2(MAX_ENTRIES)-1:0]  idx,
	input  logic                            ent_valid,
	input  logic [lkc_pkg::KEY_BITS-1:0]    ent_key,
	input  logic [$clog2(MAX_ENTRIES)-1:0]  ent_rank,
	input  logic [lkc_pkg::KEY_BITS-1:0]    req_key,
	output logic                            hit,
	output logic [$clog2(MAX_ENTRIES)-1:0]  hit_slot,
	output logic [$clog2(MAX_ENTRIES)-1:0]  hit_rank,
	output logic                            free_found,
	output logic [$clog2(MAX_ENTRIES)-1:0]  free_slot,
	output logic [$clog2(MAX_ENTRIES)-1:0]  lru_slot,
	output logic [$clog2(MAX_ENTRIES)-1:0]  lru_rank
);
	import lkc_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);

	logic          hit_q, free_q, lru_q;
	logic [IW-1:0] hit_slot_q, hit_rank_q, free_slot_q, lru_slot_q, lru_rank_q;
	logic          take_hit, take_free, take_lru;

	assign take_hit  = step && ent_valid && (ent_key == req_key) && !hit_q;
	assign take_free = step && !ent_valid && !free_q;
	assign take_lru  = step && ent_valid && (!lru_q || (ent_rank > lru_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (clr) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
			if (take_lru) begin
				lru_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_slot_q <= idx;
			hit_rank_q <= ent_rank;
		end
		if (take_free) begin
			free_slot_q <= idx;
		end
		if (take_lru) begin
			lru_slot_q <= idx;
			lru_rank_q <= ent_rank;
		end
	end

	assign hit        = hit_q;
	assign hit_slot   = hit_slot_q;
	assign hit_rank   = hit_rank_q;
	assign free_found = free_q;
	assign free_slot  = free_slot_q;
	assign lru_slot   = lru_slot_q;
	assign lru_rank   = lru_rank_q;

endmodule
